// ----- hw/rtl/source_text_tokenizer_defines.svh -----
// Assertion helpers for the tokenizer RTL, included by stt_queue.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Check outside reset.
`define STT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check at every edge, reset included.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/stt_pkg.sv -----
package stt_pkg;

   localparam int unsigned MAX_RECS    = 6;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned KW_COUNT    = 11;

   typedef enum logic [1:0] {
      REC_VALUE = 2'd0,
      REC_END   = 2'd1,
      REC_DIAG  = 2'd2
   } stt_rec_kind_type;

   // Token kinds
   localparam logic [5:0] TK_EOF     = 6'd0;
   localparam logic [5:0] TK_INT     = 6'd1;
   localparam logic [5:0] TK_FLOAT   = 6'd2;
   localparam logic [5:0] TK_IDENT   = 6'd3;
   localparam logic [5:0] TK_KW_BASE = 6'd4;
   localparam logic [5:0] TK_STRING  = 6'd15;
   localparam logic [5:0] TK_CHAR    = 6'd16;
   localparam logic [5:0] TK_LPAREN  = 6'd17;
   localparam logic [5:0] TK_RPAREN  = 6'd18;
   localparam logic [5:0] TK_LBRACK  = 6'd19;
   localparam logic [5:0] TK_RBRACK  = 6'd20;
   localparam logic [5:0] TK_LBRACE  = 6'd21;
   localparam logic [5:0] TK_RBRACE  = 6'd22;
   localparam logic [5:0] TK_COLON   = 6'd23;
   localparam logic [5:0] TK_SEMI    = 6'd24;
   localparam logic [5:0] TK_COMMA   = 6'd25;
   localparam logic [5:0] TK_DOT     = 6'd26;
   localparam logic [5:0] TK_PLUS    = 6'd27;
   localparam logic [5:0] TK_MINUS   = 6'd28;
   localparam logic [5:0] TK_ARROW   = 6'd29;
   localparam logic [5:0] TK_STAR    = 6'd30;
   localparam logic [5:0] TK_SLASH   = 6'd31;
   localparam logic [5:0] TK_PERCENT = 6'd32;
   localparam logic [5:0] TK_ASSIGN  = 6'd33;
   localparam logic [5:0] TK_EQ      = 6'd34;
   localparam logic [5:0] TK_GT      = 6'd35;
   localparam logic [5:0] TK_GE      = 6'd36;
   localparam logic [5:0] TK_LT      = 6'd37;
   localparam logic [5:0] TK_LE      = 6'd38;
   localparam logic [5:0] TK_NE      = 6'd39;

   // Diagnostic codes
   localparam logic [3:0] DG_NONE        = 4'd0;
   localparam logic [3:0] DG_OPEN_BLOCK  = 4'd1;
   localparam logic [3:0] DG_EXTRA_DOT   = 4'd2;
   localparam logic [3:0] DG_UNKNOWN     = 4'd3;
   localparam logic [3:0] DG_BAD_ESC_END = 4'd4;
   localparam logic [3:0] DG_OPEN_STRING = 4'd5;
   localparam logic [3:0] DG_LONG_CHAR   = 4'd6;
   localparam logic [3:0] DG_EMPTY_CHAR  = 4'd7;
   localparam logic [3:0] DG_OPEN_CHAR   = 4'd8;
   localparam logic [3:0] DG_NULL_ESC    = 4'd9;
   localparam logic [3:0] DG_UNKNOWN_ESC = 4'd10;

   // Characters
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_N = 8'h6e;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;

   // Keywords, right-justified text and length
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("var"), 64'("function"), 64'("void"), 64'("print"), 64'("println"),
      64'("exit"), 64'("return"), 64'("true"), 64'("false"), 64'("if"), 64'("else")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd8, 4'd4, 4'd5, 4'd7, 4'd4, 4'd6, 4'd4, 4'd5, 4'd2, 4'd4
   };

   typedef struct packed {
      stt_rec_kind_type rtype;
      logic [5:0]       kind;
      logic [7:0]       val;
      logic [3:0]       diag;
   } stt_rec_type;

   typedef struct packed {
      logic [2:0]                 count;
      stt_rec_type [MAX_RECS-1:0] rec;
   } stt_bundle_type;

   function automatic stt_bundle_type add_rec(input stt_bundle_type b,
                                              input stt_rec_kind_type t,
                                              input logic [5:0] k,
                                              input logic [7:0] v,
                                              input logic [3:0] d);
      stt_bundle_type r;
      r = b;
      r.rec[r.count] = '{rtype: t, kind: k, val: v, diag: d};
      r.count = r.count + 3'd1;
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h28:   k = TK_LPAREN;
         8'h29:   k = TK_RPAREN;
         8'h5b:   k = TK_LBRACK;
         8'h5d:   k = TK_RBRACK;
         8'h7b:   k = TK_LBRACE;
         8'h7d:   k = TK_RBRACE;
         8'h3a:   k = TK_COLON;
         8'h3b:   k = TK_SEMI;
         8'h2c:   k = TK_COMMA;
         CH_DOT:  k = TK_DOT;
         8'h2b:   k = TK_PLUS;
         CH_STAR: k = TK_STAR;
         8'h25:   k = TK_PERCENT;
         default: k = TK_EOF;
      endcase
      return k;
   endfunction

   // Drop keywords that no longer match after byte c at position pos.
   function automatic logic [KW_COUNT-1:0] kw_match(input logic [KW_COUNT-1:0] alive,
                                                    input logic [3:0] pos,
                                                    input logic [7:0] c);
      logic [KW_COUNT-1:0] r;
      int unsigned         sh;
      r = alive;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos >= KW_LEN[k]) begin
            r[k] = 1'b0;
         end else begin
            sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
            if (KW_TEXT[k][sh +: 8] != c) r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [5:0] kw_kind(input logic [KW_COUNT-1:0] alive,
                                          input logic [3:0] len);
      logic [5:0] kind;
      kind = TK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (alive[k] && (KW_LEN[k] == len)) kind = TK_KW_BASE + 6'(k);
      end
      return kind;
   endfunction

   function automatic logic [7:0] esc_value(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         CH_LOWER_N: v = CH_LF;
         CH_LOWER_R: v = CH_CR;
         CH_LOWER_T: v = CH_TAB;
         CH_LOWER_B: v = CH_BS;
         default:    v = c;
      endcase
      return v;
   endfunction

   // Close a string or char literal: warnings, errors, then the token end.
   function automatic stt_bundle_type add_finish(input stt_bundle_type b,
                                                 input logic is_chr,
                                                 input logic [1:0] len,
                                                 input logic esc,
                                                 input logic closed);
      stt_bundle_type r;
      r = b;
      if (is_chr) begin
         if (len > 2'd1) r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_LONG_CHAR);
         if (len == 2'd0) r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_EMPTY_CHAR);
         if (esc) r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_BAD_ESC_END);
         if (!closed) r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_OPEN_CHAR);
         r = add_rec(r, REC_END, TK_CHAR, 8'd0, DG_NONE);
      end else begin
         if (esc) r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_BAD_ESC_END);
         if (!closed) r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_OPEN_STRING);
         r = add_rec(r, REC_END, TK_STRING, 8'd0, DG_NONE);
      end
      return r;
   endfunction

   // Resolve a held operator as a single-byte token, or flag a lone '!' as unknown.
   function automatic stt_bundle_type add_held_alone(input stt_bundle_type b,
                                                     input logic [7:0] h);
      stt_bundle_type r;
      r = b;
      case (h)
         CH_SLASH: begin
            r = add_rec(r, REC_VALUE, TK_EOF, h, DG_NONE);
            r = add_rec(r, REC_END, TK_SLASH, 8'd0, DG_NONE);
         end
         CH_MINUS: begin
            r = add_rec(r, REC_VALUE, TK_EOF, h, DG_NONE);
            r = add_rec(r, REC_END, TK_MINUS, 8'd0, DG_NONE);
         end
         CH_BANG: r = add_rec(r, REC_DIAG, TK_EOF, 8'd0, DG_UNKNOWN);
         CH_EQ: begin
            r = add_rec(r, REC_VALUE, TK_EOF, h, DG_NONE);
            r = add_rec(r, REC_END, TK_ASSIGN, 8'd0, DG_NONE);
         end
         CH_GT: begin
            r = add_rec(r, REC_VALUE, TK_EOF, h, DG_NONE);
            r = add_rec(r, REC_END, TK_GT, 8'd0, DG_NONE);
         end
         CH_LT: begin
            r = add_rec(r, REC_VALUE, TK_EOF, h, DG_NONE);
            r = add_rec(r, REC_END, TK_LT, 8'd0, DG_NONE);
         end
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/stt_if.sv -----
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_source;

   modport source (output valid, output text_byte, output end_of_source, input ready);
   modport sink (input valid, input text_byte, input end_of_source, output ready);
endinterface

interface stt_rsp_if #(parameter int LINE_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [1:0]           record_type;
   logic [5:0]           token_kind;
   logic [7:0]           value_byte;
   logic [LINE_BITS-1:0] line_count;
   logic [3:0]           diag_code;
   logic                 last_of_run;

   modport source (output valid, output record_type, output token_kind, output value_byte,
                   output line_count, output diag_code, output last_of_run, input ready);
   modport sink (input valid, input record_type, input token_kind, input value_byte,
                 input line_count, input diag_code, input last_of_run, output ready);
endinterface

// ----- hw/rtl/stt_front.sv -----
module stt_front #(
   parameter int LINE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   stt_req_if.sink                req,
   output logic                   push,
   output stt_pkg::stt_bundle_type push_bundle,
   output logic [LINE_BITS-1:0]   push_line,
   input  logic                   full
);

   typedef enum logic [8:0] {
      M_IDLE  = 9'b000000001,
      M_HASH  = 9'b000000010,
      M_BLOCK = 9'b000000100,
      M_BSTAR = 9'b000001000,
      M_NUM   = 9'b000010000,
      M_WORD  = 9'b000100000,
      M_STR   = 9'b001000000,
      M_CHR   = 9'b010000000,
      M_HELD  = 9'b100000000
   } stt_mode_type;

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   stt_mode_type                      mode_ff, mode_in;
   logic [7:0]                        held_ff, held_in;
   logic                              esc_ff, esc_in;
   logic                              dot_ff, dot_in;
   logic [stt_pkg::KW_COUNT-1:0]      alive_ff, alive_in;
   logic [3:0]                        wpos_ff, wpos_in;
   logic [1:0]                        litlen_ff, litlen_in;
   logic [LINE_BITS-1:0]              line_ff, line_in;
   stt_pkg::stt_bundle_type           bnd;
   logic                              to_idle;
   logic                              bump;
   logic                              accept;
   logic                              is_chr;
   logic [7:0]                        c;

   assign c           = req.text_byte;
   assign req.ready   = !full;
   assign accept      = req.valid && req.ready;
   assign push        = accept && (bnd.count != 3'd0);
   assign push_bundle = bnd;
   assign push_line   = line_ff;
   assign is_chr      = (mode_ff == M_CHR);

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      esc_in    = esc_ff;
      dot_in    = dot_ff;
      alive_in  = alive_ff;
      wpos_in   = wpos_ff;
      litlen_in = litlen_ff;
      line_in   = line_ff;
      bnd       = '0;
      to_idle   = 1'b0;
      bump      = 1'b0;
      if (req.end_of_source) begin
         unique case (mode_ff)
            M_BLOCK, M_BSTAR: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_DIAG, stt_pkg::TK_EOF,
                                                     8'd0, stt_pkg::DG_OPEN_BLOCK);
            M_NUM: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                          dot_ff ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT,
                                          8'd0, stt_pkg::DG_NONE);
            M_WORD: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                           stt_pkg::kw_kind(alive_ff, wpos_ff),
                                           8'd0, stt_pkg::DG_NONE);
            M_STR, M_CHR: bnd = stt_pkg::add_finish(bnd, is_chr, litlen_ff, esc_ff, 1'b0);
            M_HELD: bnd = stt_pkg::add_held_alone(bnd, held_ff);
            default: bnd = '0;
         endcase
         bnd       = stt_pkg::add_rec(bnd, stt_pkg::REC_END, stt_pkg::TK_EOF, 8'd0,
                                      stt_pkg::DG_NONE);
         // start the next source from scratch
         mode_in   = M_IDLE;
         held_in   = 8'd0;
         esc_in    = 1'b0;
         dot_in    = 1'b0;
         alive_in  = '1;
         wpos_in   = 4'd0;
         litlen_in = 2'd0;
         line_in   = LINE_ONE;
      end else begin
         unique case (mode_ff)
            M_HASH: to_idle = (c == stt_pkg::CH_LF);
            M_BLOCK: begin
               if (c == stt_pkg::CH_STAR) mode_in = M_BSTAR;
               else bump = (c == stt_pkg::CH_LF);
            end
            M_BSTAR: begin
               if (c == stt_pkg::CH_SLASH) begin
                  mode_in = M_IDLE;
               end else if (c != stt_pkg::CH_STAR) begin
                  mode_in = M_BLOCK;
                  bump    = (c == stt_pkg::CH_LF);
               end
            end
            M_NUM: begin
               if (stt_pkg::is_digit(c)) begin
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                         stt_pkg::DG_NONE);
               end else if (c == stt_pkg::CH_DOT) begin
                  if (dot_ff) bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_DIAG, stt_pkg::TK_EOF,
                                                     8'd0, stt_pkg::DG_EXTRA_DOT);
                  dot_in = 1'b1;
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                         stt_pkg::DG_NONE);
               end else begin
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                         dot_ff ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT,
                                         8'd0, stt_pkg::DG_NONE);
                  dot_in  = 1'b0;
                  to_idle = 1'b1;
               end
            end
            M_WORD: begin
               if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == stt_pkg::CH_UNDER) begin
                  alive_in = stt_pkg::kw_match(alive_ff, wpos_ff, c);
                  if (wpos_ff != 4'd15) wpos_in = wpos_ff + 4'd1;
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                         stt_pkg::DG_NONE);
               end else begin
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                         stt_pkg::kw_kind(alive_ff, wpos_ff),
                                         8'd0, stt_pkg::DG_NONE);
                  to_idle = 1'b1;
               end
            end
            M_STR, M_CHR: begin
               if (c == stt_pkg::CH_LF) begin
                  bnd       = stt_pkg::add_finish(bnd, is_chr, litlen_ff, esc_ff, 1'b0);
                  esc_in    = 1'b0;
                  litlen_in = 2'd0;
                  to_idle   = 1'b1;
               end else if (esc_ff) begin
                  esc_in = 1'b0;
                  case (c) inside
                     stt_pkg::CH_LOWER_N, stt_pkg::CH_LOWER_R, stt_pkg::CH_LOWER_T,
                     stt_pkg::CH_LOWER_B, stt_pkg::CH_BSLASH, stt_pkg::CH_DQUOTE,
                     stt_pkg::CH_SQUOTE: bnd = bnd;
                     stt_pkg::CH_ZERO: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_DIAG,
                                                              stt_pkg::TK_EOF, 8'd0,
                                                              stt_pkg::DG_NULL_ESC);
                     default: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_DIAG, stt_pkg::TK_EOF,
                                                     8'd0, stt_pkg::DG_UNKNOWN_ESC);
                  endcase
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF,
                                         stt_pkg::esc_value(c), stt_pkg::DG_NONE);
                  if (is_chr && litlen_ff != 2'd2) litlen_in = litlen_ff + 2'd1;
               end else if (c == (is_chr ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE)) begin
                  bnd       = stt_pkg::add_finish(bnd, is_chr, litlen_ff, esc_ff, 1'b1);
                  litlen_in = 2'd0;
                  mode_in   = M_IDLE;
               end else if (c == stt_pkg::CH_BSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                         stt_pkg::DG_NONE);
                  if (is_chr && litlen_ff != 2'd2) litlen_in = litlen_ff + 2'd1;
               end
               if (c == stt_pkg::CH_LF) mode_in = M_IDLE;
            end
            M_HELD: begin
               held_in = 8'd0;
               mode_in = M_IDLE;
               if (held_ff == stt_pkg::CH_SLASH && c == stt_pkg::CH_STAR) begin
                  mode_in = M_BLOCK;
               end else if (held_ff == stt_pkg::CH_MINUS && c == stt_pkg::CH_GT) begin
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, held_ff,
                                         stt_pkg::DG_NONE);
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                         stt_pkg::DG_NONE);
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END, stt_pkg::TK_ARROW, 8'd0,
                                         stt_pkg::DG_NONE);
               end else if (c == stt_pkg::CH_EQ && (held_ff == stt_pkg::CH_BANG ||
                            held_ff == stt_pkg::CH_EQ || held_ff == stt_pkg::CH_GT ||
                            held_ff == stt_pkg::CH_LT)) begin
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, held_ff,
                                         stt_pkg::DG_NONE);
                  bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                         stt_pkg::DG_NONE);
                  case (held_ff)
                     stt_pkg::CH_BANG: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                                              stt_pkg::TK_NE, 8'd0,
                                                              stt_pkg::DG_NONE);
                     stt_pkg::CH_EQ: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                                            stt_pkg::TK_EQ, 8'd0,
                                                            stt_pkg::DG_NONE);
                     stt_pkg::CH_GT: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                                            stt_pkg::TK_GE, 8'd0,
                                                            stt_pkg::DG_NONE);
                     default: bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END,
                                                     stt_pkg::TK_LE, 8'd0, stt_pkg::DG_NONE);
                  endcase
               end else begin
                  bnd     = stt_pkg::add_held_alone(bnd, held_ff);
                  to_idle = 1'b1;
               end
            end
            default: to_idle = 1'b1;
         endcase

         // reprocess the byte as the start of a new token
         if (to_idle) begin
            mode_in = M_IDLE;
            if (c == stt_pkg::CH_HASH) begin
               mode_in = M_HASH;
            end else if (stt_pkg::is_space(c)) begin
               bump = (c == stt_pkg::CH_LF);
            end else if (stt_pkg::is_digit(c)) begin
               mode_in = M_NUM;
               dot_in  = 1'b0;
               bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                      stt_pkg::DG_NONE);
            end else if (stt_pkg::is_alpha(c) || c == stt_pkg::CH_UNDER) begin
               mode_in  = M_WORD;
               alive_in = stt_pkg::kw_match('1, 4'd0, c);
               wpos_in  = 4'd1;
               bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                      stt_pkg::DG_NONE);
            end else if (c == stt_pkg::CH_DQUOTE) begin
               mode_in = M_STR;
               esc_in  = 1'b0;
            end else if (c == stt_pkg::CH_SQUOTE) begin
               mode_in   = M_CHR;
               esc_in    = 1'b0;
               litlen_in = 2'd0;
            end else if (c == stt_pkg::CH_SLASH || c == stt_pkg::CH_MINUS ||
                         c == stt_pkg::CH_EQ || c == stt_pkg::CH_LT ||
                         c == stt_pkg::CH_GT || c == stt_pkg::CH_BANG) begin
               mode_in = M_HELD;
               held_in = c;
            end else if (stt_pkg::single_kind(c) != stt_pkg::TK_EOF) begin
               bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_VALUE, stt_pkg::TK_EOF, c,
                                      stt_pkg::DG_NONE);
               bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_END, stt_pkg::single_kind(c),
                                      8'd0, stt_pkg::DG_NONE);
            end else begin
               bnd = stt_pkg::add_rec(bnd, stt_pkg::REC_DIAG, stt_pkg::TK_EOF, 8'd0,
                                      stt_pkg::DG_UNKNOWN);
            end
         end

         // saturate the line count
         if (bump && line_ff != LINE_MAX) line_in = line_ff + LINE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         held_ff   <= 8'd0;
         esc_ff    <= 1'b0;
         dot_ff    <= 1'b0;
         alive_ff  <= '1;
         wpos_ff   <= 4'd0;
         litlen_ff <= 2'd0;
         line_ff   <= LINE_ONE;
      end else if (accept) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         esc_ff    <= esc_in;
         dot_ff    <= dot_in;
         alive_ff  <= alive_in;
         wpos_ff   <= wpos_in;
         litlen_ff <= litlen_in;
         line_ff   <= line_in;
      end
   end

endmodule

// ----- hw/rtl/stt_queue.sv -----
`include "source_text_tokenizer_defines.svh"

module stt_queue #(
   parameter int LINE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  stt_pkg::stt_bundle_type push_bundle,
   input  logic [LINE_BITS-1:0]    push_line,
   output logic                    full,
   input  logic                    pop,
   output stt_pkg::stt_bundle_type head_bundle,
   output logic [LINE_BITS-1:0]    head_line,
   output logic                    empty
);

   localparam int unsigned DEPTH    = stt_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   stt_pkg::stt_bundle_type bundle_ff [DEPTH];
   logic [LINE_BITS-1:0]    line_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ff, wr_in;
   logic [PTR_BITS-1:0]     rd_ff, rd_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;

   assign full        = (count_ff == CNT_FULL);
   assign empty       = (count_ff == '0);
   assign head_bundle = bundle_ff[rd_ff];
   assign head_line   = line_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_BITS'(1);
      if (pop) rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_BITS'(1);
      if (push && !pop) count_in = count_ff + CNT_BITS'(1);
      if (pop && !push) count_in = count_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         bundle_ff[wr_ff] <= push_bundle;
         line_ff[wr_ff]   <= push_line;
      end
   end

   `STT_ASSERT(a_no_overflow, push |-> !full, "bundle pushed into full queue")
   `STT_ASSERT(a_no_underflow, pop |-> !empty, "bundle popped from empty queue")
   `STT_ASSERT(a_push_nonempty, push |-> (push_bundle.count != 3'd0), "empty bundle queued")
   `STT_ASSERT_ALWAYS(a_reset_empty, reset |=> empty, "queue not empty after reset")

endmodule

// ----- hw/rtl/stt_back.sv -----
module stt_back #(
   parameter int LINE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stt_pkg::stt_bundle_type head_bundle,
   input  logic [LINE_BITS-1:0]    head_line,
   input  logic                    empty,
   output logic                    pop,
   stt_rsp_if.source               rsp
);

   logic [2:0]           idx_ff, idx_in;
   stt_pkg::stt_rec_type rec;
   logic                 last;
   logic                 beat;

   assign rec  = head_bundle.rec[idx_ff];
   assign last = (idx_ff == head_bundle.count - 3'd1);
   assign beat = rsp.valid && rsp.ready;
   assign pop  = beat && last;

   assign rsp.valid       = !empty;
   assign rsp.record_type = rec.rtype;
   assign rsp.token_kind  = rec.kind;
   assign rsp.value_byte  = rec.val;
   assign rsp.diag_code   = rec.diag;
   assign rsp.line_count  = head_line;
   assign rsp.last_of_run = last;

   // advance through the bundle one record per beat
   always_comb begin
      idx_in = idx_ff;
      if (beat) idx_in = last ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 3'd0;
      else idx_ff <= idx_in;
   end

endmodule

// ----- hw/rtl/source_text_tokenizer.sv -----
// Streaming source-text tokenizer.
// req_chan carries one source byte per beat (text_byte), or an end-of-source
// beat (end_of_source = 1) that closes the open token and yields the eof token.
// rsp_chan carries one record per beat: token value bytes, token-end records
// with the kind, and diagnostics; last_of_run marks the final record of a byte.
// Each accepted byte is classified combinationally and its records (none up to six)
// are placed as a bundle into a two-entry queue; the back end drains one record
// per cycle while the receiver is ready. Records are registered in the queue
// before rsp_chan shows them. Bytes are accepted one per cycle while the queue
// has room; the drain rate of the record port is what sets this pace.
// Reset clears the lexer state, sets the line count to one and empties the
// queue. When the receiver stalls, records wait in the queue; req_chan.ready
// drops once both queue entries are taken and rises again as a bundle drains.
module source_text_tokenizer #(
   parameter int LINE_BITS = 24
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_chan,
   stt_rsp_if.source rsp_chan
);

   logic                    push;
   logic                    pop;
   logic                    full;
   logic                    empty;
   stt_pkg::stt_bundle_type push_bundle;
   stt_pkg::stt_bundle_type head_bundle;
   logic [LINE_BITS-1:0]    push_line;
   logic [LINE_BITS-1:0]    head_line;

   stt_front #(.LINE_BITS(LINE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .push        (push),
      .push_bundle (push_bundle),
      .push_line   (push_line),
      .full        (full)
   );

   stt_queue #(.LINE_BITS(LINE_BITS)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .push_line   (push_line),
      .full        (full),
      .pop         (pop),
      .head_bundle (head_bundle),
      .head_line   (head_line),
      .empty       (empty)
   );

   stt_back #(.LINE_BITS(LINE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_bundle (head_bundle),
      .head_line   (head_line),
      .empty       (empty),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule

// ----- test/stt_tb_if.sv -----
interface stt_tb_knobs;
   int unsigned src_idle_pct;
   int unsigned snk_idle_pct;
endinterface

// ----- test/stt_checker.sv -----
module stt_checker #(
   parameter int LINE_BITS = 24
) (
   input  logic   clock,
   input  logic   reset,
   stt_req_if     req_chan,
   stt_rsp_if     rsp_chan,
   output int     fail_count,
   output int     pending_count
);

   typedef enum logic [3:0] {
      LX_IDLE, LX_HASH, LX_BLOCK, LX_BSTAR, LX_NUM, LX_WORD, LX_STR, LX_CHR, LX_HELD
   } lex_mode_type;

   typedef struct packed {
      logic [1:0]           rtype;
      logic [5:0]           kind;
      logic [7:0]           val;
      logic [LINE_BITS-1:0] line;
      logic [3:0]           diag;
      logic                 last;
   } record_type;

   localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};
   localparam logic [10:0]          ALL_KW   = 11'h7ff;

   record_type     expected_records[$];
   record_type     step_records[$];
   lex_mode_type   mode;
   logic [7:0]     held;
   logic           esc_open;
   logic           dot_seen;
   logic [10:0]    kw_live;
   logic [3:0]     word_pos;
   logic [1:0]     lit_len;
   logic [LINE_BITS-1:0] line_no;
   record_type     seen;
   record_type     want;

   assign pending_count = expected_records.size();

   function automatic string kw_word(int k);
      case (k)
         0: return "var";      1: return "function"; 2: return "void";
         3: return "print";    4: return "println";  5: return "exit";
         6: return "return";   7: return "true";     8: return "false";
         9: return "if";       default: return "else";
      endcase
   endfunction

   function automatic int kw_length(int k);
      string s;
      s = kw_word(k);
      return s.len();
   endfunction

   task automatic push_rec(logic [1:0] t, logic [5:0] k, logic [7:0] v, logic [3:0] d);
      record_type r;
      r = '{rtype: t, kind: k, val: v, line: line_no, diag: d, last: 1'b0};
      step_records.insert(step_records.size(), r);
   endtask

   task automatic push_value(logic [7:0] v);
      push_rec(stt_pkg::REC_VALUE, stt_pkg::TK_EOF, v, stt_pkg::DG_NONE);
   endtask

   task automatic push_end(logic [5:0] k);
      push_rec(stt_pkg::REC_END, k, 8'd0, stt_pkg::DG_NONE);
   endtask

   task automatic push_diag(logic [3:0] d);
      push_rec(stt_pkg::REC_DIAG, stt_pkg::TK_EOF, 8'd0, d);
   endtask

   task automatic count_line();
      if (line_no != LINE_TOP) line_no = line_no + LINE_BITS'(1);
   endtask

   function automatic logic digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   task automatic clear_state();
      mode = LX_IDLE; held = 8'd0; esc_open = 1'b0; dot_seen = 1'b0;
      kw_live = ALL_KW; word_pos = 4'd0; lit_len = 2'd0; line_no = LINE_BITS'(1);
   endtask

   task automatic track_word(logic [7:0] c);
      string s;
      for (int k = 0; k < 11; k++) begin
         s = kw_word(k);
         if (word_pos >= s.len() || s[word_pos] != c) kw_live[k] = 1'b0;
      end
      if (word_pos != 4'd15) word_pos = word_pos + 4'd1;
   endtask

   task automatic close_word();
      logic [5:0] k;
      k = stt_pkg::TK_IDENT;
      for (int i = 0; i < 11; i++)
         if (kw_live[i] && kw_length(i) == word_pos) k = stt_pkg::TK_KW_BASE + 6'(i);
      push_end(k);
      mode = LX_IDLE;
   endtask

   task automatic close_number();
      push_end(dot_seen ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT);
      dot_seen = 1'b0;
      mode = LX_IDLE;
   endtask

   task automatic close_literal(logic closed);
      if (mode == LX_CHR) begin
         if (lit_len > 2'd1) push_diag(stt_pkg::DG_LONG_CHAR);
         if (lit_len == 2'd0) push_diag(stt_pkg::DG_EMPTY_CHAR);
         if (esc_open) push_diag(stt_pkg::DG_BAD_ESC_END);
         if (!closed) push_diag(stt_pkg::DG_OPEN_CHAR);
         push_end(stt_pkg::TK_CHAR);
      end else begin
         if (esc_open) push_diag(stt_pkg::DG_BAD_ESC_END);
         if (!closed) push_diag(stt_pkg::DG_OPEN_STRING);
         push_end(stt_pkg::TK_STRING);
      end
      esc_open = 1'b0; lit_len = 2'd0; mode = LX_IDLE;
   endtask

   task automatic append_literal(logic [7:0] c);
      push_value(c);
      if (mode == LX_CHR && lit_len < 2'd2) lit_len = lit_len + 2'd1;
   endtask

   function automatic logic [5:0] symbol_kind(logic [7:0] c);
      case (c)
         "(": return stt_pkg::TK_LPAREN;  ")": return stt_pkg::TK_RPAREN;
         "[": return stt_pkg::TK_LBRACK;  "]": return stt_pkg::TK_RBRACK;
         "{": return stt_pkg::TK_LBRACE;  "}": return stt_pkg::TK_RBRACE;
         ":": return stt_pkg::TK_COLON;   ";": return stt_pkg::TK_SEMI;
         ",": return stt_pkg::TK_COMMA;   ".": return stt_pkg::TK_DOT;
         "+": return stt_pkg::TK_PLUS;    "*": return stt_pkg::TK_STAR;
         "%": return stt_pkg::TK_PERCENT;
         default: return stt_pkg::TK_EOF;
      endcase
   endfunction

   task automatic start_token(logic [7:0] c);
      logic [5:0] k;
      if (c == "#") begin
         mode = LX_HASH;
      end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
         if (c == stt_pkg::CH_LF) count_line();
      end else if (digit(c)) begin
         mode = LX_NUM; dot_seen = 1'b0; push_value(c);
      end else if (letter(c) || c == "_") begin
         mode = LX_WORD; kw_live = ALL_KW; word_pos = 4'd0;
         track_word(c); push_value(c);
      end else if (c == stt_pkg::CH_DQUOTE) begin
         mode = LX_STR; esc_open = 1'b0;
      end else if (c == stt_pkg::CH_SQUOTE) begin
         mode = LX_CHR; esc_open = 1'b0; lit_len = 2'd0;
      end else if (c == "/" || c == "-" || c == "=" || c == "<" || c == ">" || c == "!") begin
         mode = LX_HELD; held = c;
      end else begin
         k = symbol_kind(c);
         if (k != stt_pkg::TK_EOF) begin
            push_value(c); push_end(k);
         end else begin
            push_diag(stt_pkg::DG_UNKNOWN);
         end
      end
   endtask

   task automatic resolve_operator(logic [7:0] c, logic have);
      logic [7:0] h;
      logic       pair;
      logic [5:0] one, two;
      h = held; pair = have && c == "=";
      one = stt_pkg::TK_EOF; two = stt_pkg::TK_EOF;
      mode = LX_IDLE; held = 8'd0;
      case (h)
         "/": begin
            if (have && c == "*") begin
               mode = LX_BLOCK;
               return;
            end
            push_value("/"); push_end(stt_pkg::TK_SLASH);
         end
         "-": begin
            if (have && c == ">") begin
               push_value("-"); push_value(">"); push_end(stt_pkg::TK_ARROW);
               return;
            end
            push_value("-"); push_end(stt_pkg::TK_MINUS);
         end
         "!": begin
            if (pair) begin
               push_value("!"); push_value("="); push_end(stt_pkg::TK_NE);
               return;
            end
            push_diag(stt_pkg::DG_UNKNOWN);
         end
         "=": begin one = stt_pkg::TK_ASSIGN; two = stt_pkg::TK_EQ; end
         ">": begin one = stt_pkg::TK_GT; two = stt_pkg::TK_GE; end
         "<": begin one = stt_pkg::TK_LT; two = stt_pkg::TK_LE; end
         default: ;
      endcase
      if (one != stt_pkg::TK_EOF) begin
         push_value(h);
         if (pair) begin
            push_value("="); push_end(two);
            return;
         end
         push_end(one);
      end
      if (have) start_token(c);
   endtask

   function automatic logic [7:0] unescape(logic [7:0] c, output logic [3:0] d);
      d = stt_pkg::DG_NONE;
      case (c)
         "n": return stt_pkg::CH_LF;
         "r": return stt_pkg::CH_CR;
         "t": return stt_pkg::CH_TAB;
         "b": return stt_pkg::CH_BS;
         "\\", stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE: return c;
         "0": begin d = stt_pkg::DG_NULL_ESC; return c; end
         default: begin d = stt_pkg::DG_UNKNOWN_ESC; return c; end
      endcase
   endfunction

   task automatic predict_beat(logic [7:0] c, logic eos);
      logic [7:0] v;
      logic [3:0] d;
      step_records.delete();
      if (eos) begin
         case (mode)
            LX_BLOCK, LX_BSTAR: push_diag(stt_pkg::DG_OPEN_BLOCK);
            LX_NUM:             close_number();
            LX_WORD:            close_word();
            LX_STR, LX_CHR:     close_literal(1'b0);
            LX_HELD:            resolve_operator(8'd0, 1'b0);
            default: ;
         endcase
         push_end(stt_pkg::TK_EOF);
         clear_state();
      end else begin
         case (mode)
            LX_HASH: if (c == stt_pkg::CH_LF) begin
               mode = LX_IDLE; start_token(c);
            end
            LX_BLOCK: begin
               if (c == "*") mode = LX_BSTAR;
               else if (c == stt_pkg::CH_LF) count_line();
            end
            LX_BSTAR: begin
               if (c == "/") mode = LX_IDLE;
               else if (c != "*") begin
                  mode = LX_BLOCK;
                  if (c == stt_pkg::CH_LF) count_line();
               end
            end
            LX_NUM: begin
               if (digit(c)) push_value(c);
               else if (c == ".") begin
                  if (dot_seen) push_diag(stt_pkg::DG_EXTRA_DOT);
                  dot_seen = 1'b1; push_value(c);
               end else begin
                  close_number(); start_token(c);
               end
            end
            LX_WORD: begin
               if (letter(c) || digit(c) || c == "_") begin
                  track_word(c); push_value(c);
               end else begin
                  close_word(); start_token(c);
               end
            end
            LX_STR, LX_CHR: begin
               if (c == stt_pkg::CH_LF) begin
                  close_literal(1'b0); start_token(c);
               end else if (esc_open) begin
                  esc_open = 1'b0;
                  v = unescape(c, d);
                  if (d != stt_pkg::DG_NONE) push_diag(d);
                  append_literal(v);
               end else if (c == ((mode == LX_STR) ? stt_pkg::CH_DQUOTE
                                                   : stt_pkg::CH_SQUOTE)) begin
                  close_literal(1'b1);
               end else if (c == "\\") begin
                  esc_open = 1'b1;
               end else begin
                  append_literal(c);
               end
            end
            LX_HELD: resolve_operator(c, 1'b1);
            default: begin
               mode = LX_IDLE; start_token(c);
            end
         endcase
      end
      if (step_records.size() > 0) step_records[step_records.size()-1].last = 1'b1;
      foreach (step_records[i]) expected_records.insert(expected_records.size(), step_records[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_records.delete();
         fail_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_beat(req_chan.text_byte, req_chan.end_of_source);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rtype: rsp_chan.record_type, kind: rsp_chan.token_kind,
                     val: rsp_chan.value_byte, line: rsp_chan.line_count,
                     diag: rsp_chan.diag_code, last: rsp_chan.last_of_run};
            if (expected_records.size() == 0) begin
               $display("%0t: record with nothing expected: expected none actual %p",
                        $time, seen);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_records.pop_front();
               if (seen !== want) begin
                  $display("%0t: record mismatch: expected %p actual %p", $time, want, seen);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- test/tb.sv -----
module tb;

   localparam int LINE_BITS = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   logic long_hold;
   int   sent;
   int   phase_start;

   stt_tb_knobs                       knobs();
   stt_req_if                         req_chan();
   stt_rsp_if #(.LINE_BITS(LINE_BITS)) rsp_chan();

   source_text_tokenizer #(.LINE_BITS(LINE_BITS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stt_checker #(.LINE_BITS(LINE_BITS)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   initial begin
      #20000000;
      $display("source_text_tokenizer verification failed");
      $finish;
   end

   // receiver side: random stalls plus an optional long hold
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) rsp_chan.ready <= 1'b0;
         else rsp_chan.ready <= ($urandom_range(99) >= knobs.snk_idle_pct);
      end
   end

   // leave valid up after the beat; the next sender action drives it
   task automatic send_beat(logic [7:0] c, logic eos);
      while ($urandom_range(99) < knobs.src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.text_byte     <= c;
      req_chan.end_of_source <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic send_snippet();
      string pieces[16];
      string s;
      pieces = '{"var x = 12;\n", "function f(a, b) { return a -> b; }\n",
                 "if (x >= 3.14) print(\"hi\\n\");\n", "else { println('c'); }\n",
                 "# note\nexit 0;\n", "/* blk\n * x */ y <= z != w\n",
                 "true false void 1.2.3\n", "'ab' '' '\\q' \"\\0\"\n",
                 "a==b%c*d/e\n", "[x] : _id9 ! @\n", "\"open\n", "'\\\n",
                 "printx prin returned\n", "x - -y > =\n", "\"t\\t\\r\\b\\\\\\\"\\'\"\n",
                 "/**/ // /*a**/\n"};
      s = pieces[$urandom_range(15)];
      for (int j = 0; j < s.len(); j++) begin
         // mutate some content but keep structure mostly intact
         if ($urandom_range(9) == 0) begin
            if (s[j] >= "a" && s[j] <= "z") s[j] = 8'($urandom_range("a", "z"));
            else if (s[j] >= "0" && s[j] <= "9") s[j] = 8'($urandom_range("0", "9"));
         end
      end
      send_text(s);
   endtask

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.text_byte     = 8'd0;
      req_chan.end_of_source = 1'b0;
      long_hold          = 1'b0;
      knobs.src_idle_pct = 0;
      knobs.snk_idle_pct = 0;
      sent               = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, escapes, held operators, end of source
      send_beat(8'h00, 1'b0);
      send_beat(8'hff, 1'b0);
      send_beat(8'h80, 1'b0);
      send_text(" a9\n");
      send_text("-> != !x <=\n\"\\x\"'ab'");
      send_beat(8'h55, 1'b1);
      send_text("/* open");
      send_beat(8'haa, 1'b1);
      send_text("'\\");
      send_beat(8'd0, 1'b1);
      send_text("9.1.");
      send_beat(8'd0, 1'b1);
      wait_drained();

      knobs.src_idle_pct = 30; knobs.snk_idle_pct = 48;
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin knobs.src_idle_pct = 48; knobs.snk_idle_pct = 30; end
         if (ph == 2) begin knobs.src_idle_pct = 0;  knobs.snk_idle_pct = 0;  end
         phase_start = sent;
         while (sent - phase_start < 70) begin
            if ($urandom_range(4) == 0) send_beat(8'($urandom), 1'b0);
            else send_snippet();
            if ($urandom_range(15) == 0) send_beat(8'($urandom), 1'b1);
         end
         if (ph == 0) begin
            // stall the receiver while bytes keep coming
            long_hold = 1'b1;
            fork
               begin repeat (60) @(posedge clock); long_hold = 1'b0; end
               send_text("a+b+c+d+e+f+g+h\n");
            join
         end
         send_beat(8'd0, 1'b1);
         wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("source_text_tokenizer verification clean");
      else
         $display("source_text_tokenizer verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_if.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer.sv
test/stt_tb_if.sv
test/stt_checker.sv
test/tb.sv
